FILE: hw/rtl/dns_answer_address_extract_assert.svh
// Assertion macros used by the RTL of the answer address extractor.
`ifndef DNS_ANSWER_ADDRESS_EXTRACT_ASSERT_SVH
`define DNS_ANSWER_ADDRESS_EXTRACT_ASSERT_SVH

// Condition in the same cycle.
`define DNSAE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnsae check failed");

// Condition in the next cycle.
`define DNSAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnsae check failed");

`endif

FILE: hw/rtl/dnsae_pkg.sv
package dnsae_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NAME_CHAR  = 2'd0;
    localparam kind_t KIND_ADDRESS    = 2'd1;
    localparam kind_t KIND_NO_ADDRESS = 2'd2;
    localparam kind_t KIND_MALFORMED  = 2'd3;

    localparam logic [3:0]  HEADER_LAST_POS   = 4'd11;
    localparam logic [3:0]  QCOUNT_HI_POS     = 4'd4;
    localparam logic [3:0]  QCOUNT_LO_POS     = 4'd5;
    localparam logic [3:0]  ACOUNT_HI_POS     = 4'd6;
    localparam logic [3:0]  ACOUNT_LO_POS     = 4'd7;
    localparam logic [7:0]  LABEL_LEN_MAX     = 8'd63;
    localparam logic [7:0]  POINTER_MASK      = 8'hc0;
    localparam logic [7:0]  DOT_CHAR          = 8'h2e;
    localparam logic [15:0] QUESTION_TAIL_LEN = 16'd4;
    localparam logic [3:0]  FIXED_SHIFT_LEN   = 4'd8;
    localparam logic [3:0]  FIXED_LAST_POS    = 4'd9;
    localparam logic [3:0]  ADDR_LAST_POS     = 4'd3;
    localparam logic [15:0] TYPE_A            = 16'd1;

endpackage

FILE: hw/rtl/dnsae_msg_if.sv
interface dnsae_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/dnsae_result_if.sv
interface dnsae_result_if
    import dnsae_pkg::*;
;
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [7:0]  name_char;
    logic [15:0] question_index;
    logic [31:0] ipv4_address;
    logic [31:0] time_to_live;
    logic [15:0] record_class;

    modport source (output valid, output kind, output name_char, output question_index,
                    output ipv4_address, output time_to_live, output record_class,
                    input ready);
    modport sink (input valid, input kind, input name_char, input question_index,
                  input ipv4_address, input time_to_live, input record_class,
                  output ready);
endinterface

FILE: hw/rtl/dns_answer_address_extract.sv
// DNS answer address extractor.
// msg (sink): one request per byte of a DNS response, header first; last_byte
//   marks the final byte of the message.
// result (source): zero or one request per byte: a decoded question name
//   character (or the dot between labels), the address record of the first
//   type-1 answer with its TTL and class, or, on the last byte, a "no address"
//   or "malformed" status which replaces any character from that byte.
// Timing: a byte is captured in the input register at its accepting edge and
//   parsed into the result register, which drives result.valid, once that
//   register has room. The parser is a single state machine updated once per
//   byte, so one byte is accepted every cycle while the result side takes its
//   requests.
// Stall: while a result waits, the next byte stays unparsed in the input
//   register and msg.ready falls; msg.ready follows result.ready in the same
//   cycle, so no bubble is inserted when the receiver releases.
// Reset: rst_n clears both registers and returns the parser to the header
//   phase. After each last byte the parser resets itself for the next message.
module dns_answer_address_extract
    import dnsae_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dnsae_msg_if.sink             msg,
    dnsae_result_if.source        result
);

`include "dns_answer_address_extract_assert.svh"

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QSKIP,
        PH_ANAME,
        PH_APTR,
        PH_AFIX,
        PH_ADDR,
        PH_RSKIP,
        PH_DONE,
        PH_BAD
    } phase_t;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  data_reg;
    logic        last_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  header_position_reg, header_position_next;
    logic [15:0] questions_left_reg, questions_left_next;
    logic [15:0] answers_left_reg, answers_left_next;
    logic [5:0]  label_bytes_left_reg, label_bytes_left_next;
    logic [3:0]  field_position_reg, field_position_next;
    logic [63:0] field_shift_reg, field_shift_next;
    logic [15:0] skip_left_reg, skip_left_next;
    logic [23:0] address_accumulator_reg, address_accumulator_next;
    logic        first_label_reg, first_label_next;
    logic [15:0] current_question_reg, current_question_next;
    logic        record_found_reg, record_found_next;

    // Result register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [7:0]  out_name_char_reg;
    logic [15:0] out_question_index_reg;
    logic [31:0] out_ipv4_address_reg;
    logic [31:0] out_time_to_live_reg;
    logic [15:0] out_record_class_reg;

    // Result of the byte in the input register
    logic        res_valid;
    kind_t       res_kind;
    logic [7:0]  res_name_char;
    logic [15:0] res_question_index;
    logic [31:0] res_ipv4_address;
    logic [31:0] res_time_to_live;
    logic [15:0] res_record_class;

    logic        advance;

    // Parse the held byte once the result register has room.
    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign msg.ready = !in_valid_reg || advance;

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_kind_reg;
    assign result.name_char      = out_name_char_reg;
    assign result.question_index = out_question_index_reg;
    assign result.ipv4_address   = out_ipv4_address_reg;
    assign result.time_to_live   = out_time_to_live_reg;
    assign result.record_class   = out_record_class_reg;

    always_comb
    begin
        phase_next               = phase_reg;
        header_position_next     = header_position_reg;
        questions_left_next      = questions_left_reg;
        answers_left_next        = answers_left_reg;
        label_bytes_left_next    = label_bytes_left_reg;
        field_position_next      = field_position_reg;
        field_shift_next         = field_shift_reg;
        skip_left_next           = skip_left_reg;
        address_accumulator_next = address_accumulator_reg;
        first_label_next         = first_label_reg;
        current_question_next    = current_question_reg;
        record_found_next        = record_found_reg;

        res_valid          = 1'b0;
        res_kind           = KIND_NAME_CHAR;
        res_name_char      = '0;
        res_question_index = '0;
        res_ipv4_address   = '0;
        res_time_to_live   = '0;
        res_record_class   = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                // Pick up the question and answer counts, ignore the rest.
                if (header_position_reg == QCOUNT_HI_POS ||
                    header_position_reg == QCOUNT_LO_POS)
                begin
                    questions_left_next = {questions_left_reg[7:0], data_reg};
                end
                else if (header_position_reg == ACOUNT_HI_POS ||
                         header_position_reg == ACOUNT_LO_POS)
                begin
                    answers_left_next = {answers_left_reg[7:0], data_reg};
                end
                if (header_position_reg >= HEADER_LAST_POS)
                begin
                    if (questions_left_next != '0)
                    begin
                        phase_next            = PH_QNAME;
                        first_label_next      = 1'b1;
                        label_bytes_left_next = '0;
                    end
                    else if (answers_left_next != '0)
                    begin
                        phase_next            = PH_ANAME;
                        label_bytes_left_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                else
                begin
                    header_position_next = header_position_reg + 4'd1;
                end
            end
            PH_QNAME:
            begin
                if (label_bytes_left_reg != '0)
                begin
                    res_valid             = 1'b1;
                    res_name_char         = data_reg;
                    res_question_index    = current_question_reg;
                    label_bytes_left_next = label_bytes_left_reg - 6'd1;
                end
                else if (data_reg == '0)
                begin
                    phase_next     = PH_QSKIP;
                    skip_left_next = QUESTION_TAIL_LEN;
                end
                else if (data_reg <= LABEL_LEN_MAX)
                begin
                    // Dot between labels, none before the first.
                    if (!first_label_reg)
                    begin
                        res_valid          = 1'b1;
                        res_name_char      = DOT_CHAR;
                        res_question_index = current_question_reg;
                    end
                    first_label_next      = 1'b0;
                    label_bytes_left_next = data_reg[5:0];
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_QSKIP:
            begin
                skip_left_next = skip_left_reg - 16'd1;
                if (skip_left_next == '0)
                begin
                    questions_left_next   = questions_left_reg - 16'd1;
                    current_question_next = current_question_reg + 16'd1;
                    if (questions_left_next != '0)
                    begin
                        phase_next            = PH_QNAME;
                        first_label_next      = 1'b1;
                        label_bytes_left_next = '0;
                    end
                    else if (answers_left_reg != '0)
                    begin
                        phase_next            = PH_ANAME;
                        label_bytes_left_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_ANAME:
            begin
                if (label_bytes_left_reg != '0)
                begin
                    label_bytes_left_next = label_bytes_left_reg - 6'd1;
                end
                else if ((data_reg & POINTER_MASK) == POINTER_MASK)
                begin
                    phase_next = PH_APTR;
                end
                else if (data_reg != '0 && data_reg <= LABEL_LEN_MAX)
                begin
                    label_bytes_left_next = data_reg[5:0];
                end
                else
                begin
                    // Root label or odd length byte: name ends here.
                    phase_next          = PH_AFIX;
                    field_position_next = '0;
                    field_shift_next    = '0;
                    skip_left_next      = '0;
                end
            end
            PH_APTR:
            begin
                phase_next          = PH_AFIX;
                field_position_next = '0;
                field_shift_next    = '0;
                skip_left_next      = '0;
            end
            PH_AFIX:
            begin
                // Type, class and TTL shift in; then the data length.
                if (field_position_reg < FIXED_SHIFT_LEN)
                begin
                    field_shift_next = {field_shift_reg[55:0], data_reg};
                end
                else
                begin
                    skip_left_next = {skip_left_reg[7:0], data_reg};
                end
                if (field_position_reg >= FIXED_LAST_POS)
                begin
                    if (field_shift_next[63:48] == TYPE_A)
                    begin
                        phase_next               = PH_ADDR;
                        field_position_next      = '0;
                        address_accumulator_next = '0;
                    end
                    else if (skip_left_next != '0)
                    begin
                        phase_next = PH_RSKIP;
                    end
                    else
                    begin
                        answers_left_next = answers_left_reg - 16'd1;
                        phase_next        = (answers_left_next != '0) ? PH_ANAME : PH_DONE;
                        if (answers_left_next != '0)
                        begin
                            label_bytes_left_next = '0;
                        end
                    end
                end
                else
                begin
                    field_position_next = field_position_reg + 4'd1;
                end
            end
            PH_ADDR:
            begin
                if (field_position_reg >= ADDR_LAST_POS)
                begin
                    res_valid         = 1'b1;
                    res_kind          = KIND_ADDRESS;
                    res_ipv4_address  = {address_accumulator_reg, data_reg};
                    res_time_to_live  = field_shift_reg[31:0];
                    res_record_class  = field_shift_reg[47:32];
                    record_found_next = 1'b1;
                    phase_next        = PH_DONE;
                end
                else
                begin
                    address_accumulator_next = {address_accumulator_reg[15:0], data_reg};
                    field_position_next      = field_position_reg + 4'd1;
                end
            end
            PH_RSKIP:
            begin
                skip_left_next = skip_left_reg - 16'd1;
                if (skip_left_next == '0)
                begin
                    answers_left_next = answers_left_reg - 16'd1;
                    phase_next        = (answers_left_next != '0) ? PH_ANAME : PH_DONE;
                    if (answers_left_next != '0)
                    begin
                        label_bytes_left_next = '0;
                    end
                end
            end
            default:
            begin
                // Done or malformed: drop the byte.
            end
        endcase

        if (last_reg)
        begin
            // Report the message status, then start over for the next message.
            if (phase_next == PH_BAD)
            begin
                res_valid          = 1'b1;
                res_kind           = KIND_MALFORMED;
                res_name_char      = '0;
                res_question_index = '0;
                res_ipv4_address   = '0;
                res_time_to_live   = '0;
                res_record_class   = '0;
            end
            else if (!record_found_next)
            begin
                res_valid          = 1'b1;
                res_kind           = KIND_NO_ADDRESS;
                res_name_char      = '0;
                res_question_index = '0;
                res_ipv4_address   = '0;
                res_time_to_live   = '0;
                res_record_class   = '0;
            end
            phase_next               = PH_HEADER;
            header_position_next     = '0;
            questions_left_next      = '0;
            answers_left_next        = '0;
            label_bytes_left_next    = '0;
            field_position_next      = '0;
            field_shift_next         = '0;
            skip_left_next           = '0;
            address_accumulator_next = '0;
            first_label_next         = 1'b1;
            current_question_next    = '0;
            record_found_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            data_reg                <= '0;
            last_reg                <= 1'b0;
            phase_reg               <= PH_HEADER;
            header_position_reg     <= '0;
            questions_left_reg      <= '0;
            answers_left_reg        <= '0;
            label_bytes_left_reg    <= '0;
            field_position_reg      <= '0;
            field_shift_reg         <= '0;
            skip_left_reg           <= '0;
            address_accumulator_reg <= '0;
            first_label_reg         <= 1'b1;
            current_question_reg    <= '0;
            record_found_reg        <= 1'b0;
            out_valid_reg           <= 1'b0;
            out_kind_reg            <= KIND_NAME_CHAR;
            out_name_char_reg       <= '0;
            out_question_index_reg  <= '0;
            out_ipv4_address_reg    <= '0;
            out_time_to_live_reg    <= '0;
            out_record_class_reg    <= '0;
        end
        else
        begin
            // Capture a new byte whenever the input register frees up.
            if (msg.ready)
            begin
                in_valid_reg <= msg.valid;
                data_reg     <= msg.data_byte;
                last_reg     <= msg.last_byte;
            end

            if (advance)
            begin
                phase_reg               <= phase_next;
                header_position_reg     <= header_position_next;
                questions_left_reg      <= questions_left_next;
                answers_left_reg        <= answers_left_next;
                label_bytes_left_reg    <= label_bytes_left_next;
                field_position_reg      <= field_position_next;
                field_shift_reg         <= field_shift_next;
                skip_left_reg           <= skip_left_next;
                address_accumulator_reg <= address_accumulator_next;
                first_label_reg         <= first_label_next;
                current_question_reg    <= current_question_next;
                record_found_reg        <= record_found_next;
                out_valid_reg           <= res_valid;
                out_kind_reg            <= res_kind;
                out_name_char_reg       <= res_name_char;
                out_question_index_reg  <= res_question_index;
                out_ipv4_address_reg    <= res_ipv4_address;
                out_time_to_live_reg    <= res_time_to_live;
                out_record_class_reg    <= res_record_class;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `DNSAE_ASSERT_NEXT(a_last_resets, clk, rst_n, advance && last_reg, phase_reg == PH_HEADER && header_position_reg == '0 && !record_found_reg)
    `DNSAE_ASSERT_SAME(a_found_done, clk, rst_n, record_found_reg, phase_reg == PH_DONE)
    `DNSAE_ASSERT_SAME(a_label_phase, clk, rst_n, label_bytes_left_reg != '0, phase_reg == PH_QNAME || phase_reg == PH_ANAME)
    `DNSAE_ASSERT_SAME(a_addr_clean, clk, rst_n, out_valid_reg && out_kind_reg == KIND_ADDRESS, out_name_char_reg == '0 && out_question_index_reg == '0)

endmodule

FILE: sim/address_extract_checker.sv
module address_extract_checker
    import dnsae_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    dnsae_msg_if     msg,
    dnsae_result_if  result,
    output int       failures,
    output int       outstanding
);

    typedef enum logic [3:0] {
        PARSE_HEADER,
        PARSE_QNAME,
        PARSE_QSKIP,
        PARSE_ANAME,
        PARSE_APTR,
        PARSE_AFIX,
        PARSE_ADDR,
        PARSE_RSKIP,
        PARSE_DONE,
        PARSE_BAD
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  name_char;
        logic [15:0] question_index;
        logic [31:0] ipv4_address;
        logic [31:0] time_to_live;
        logic [15:0] record_class;
    } extract_item_t;

    parse_state_t  parse_state;
    logic [3:0]    hdr_pos;
    logic [15:0]   q_left;
    logic [15:0]   a_left;
    logic [5:0]    label_left;
    logic [3:0]    fld_pos;
    logic [63:0]   fixed_bits;
    logic [15:0]   skip_cnt;
    logic [23:0]   addr_acc;
    logic          first_lbl;
    logic [15:0]   q_index;
    logic          found;

    extract_item_t expected_items[$];

    function automatic void reset_parser();
        parse_state = PARSE_HEADER;
        hdr_pos     = '0;
        q_left      = '0;
        a_left      = '0;
        label_left  = '0;
        fld_pos     = '0;
        fixed_bits  = '0;
        skip_cnt    = '0;
        addr_acc    = '0;
        first_lbl   = 1'b1;
        q_index     = '0;
        found       = 1'b0;
    endfunction

    function automatic void after_questions();
        if (q_left != 0) begin
            parse_state = PARSE_QNAME;
            first_lbl   = 1'b1;
            label_left  = '0;
        end else if (a_left != 0) begin
            parse_state = PARSE_ANAME;
            label_left  = '0;
        end else begin
            parse_state = PARSE_DONE;
        end
    endfunction

    function automatic void start_fixed();
        parse_state = PARSE_AFIX;
        fld_pos     = '0;
        fixed_bits  = '0;
        skip_cnt    = '0;
    endfunction

    function automatic void next_answer();
        a_left = a_left - 16'd1;
        if (a_left != 0) begin
            parse_state = PARSE_ANAME;
            label_left  = '0;
        end else begin
            parse_state = PARSE_DONE;
        end
    endfunction

    // Advance the parser by one message byte; queue the result it causes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        extract_item_t item;
        logic          emit;
        item = '0;
        emit = 1'b0;
        case (parse_state)
            PARSE_HEADER:
            begin
                if (hdr_pos == QCOUNT_HI_POS || hdr_pos == QCOUNT_LO_POS)
                    q_left = {q_left[7:0], b};
                else if (hdr_pos == ACOUNT_HI_POS || hdr_pos == ACOUNT_LO_POS)
                    a_left = {a_left[7:0], b};
                if (hdr_pos >= HEADER_LAST_POS)
                    after_questions();
                else
                    hdr_pos = hdr_pos + 4'd1;
            end
            PARSE_QNAME:
            begin
                if (label_left != 0) begin
                    item.kind           = KIND_NAME_CHAR;
                    item.name_char      = b;
                    item.question_index = q_index;
                    emit                = 1'b1;
                    label_left          = label_left - 6'd1;
                end else if (b == 8'd0) begin
                    parse_state = PARSE_QSKIP;
                    skip_cnt    = QUESTION_TAIL_LEN;
                end else if (b <= LABEL_LEN_MAX) begin
                    if (!first_lbl) begin
                        item.kind           = KIND_NAME_CHAR;
                        item.name_char      = DOT_CHAR;
                        item.question_index = q_index;
                        emit                = 1'b1;
                    end
                    first_lbl  = 1'b0;
                    label_left = b[5:0];
                end else begin
                    parse_state = PARSE_BAD;
                end
            end
            PARSE_QSKIP:
            begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0) begin
                    q_left  = q_left - 16'd1;
                    q_index = q_index + 16'd1;
                    after_questions();
                end
            end
            PARSE_ANAME:
            begin
                if (label_left != 0)
                    label_left = label_left - 6'd1;
                else if ((b & POINTER_MASK) == POINTER_MASK)
                    parse_state = PARSE_APTR;
                else if (b >= 8'd1 && b <= LABEL_LEN_MAX)
                    label_left = b[5:0];
                else
                    start_fixed();
            end
            PARSE_APTR:
            begin
                start_fixed();
            end
            PARSE_AFIX:
            begin
                if (fld_pos < FIXED_SHIFT_LEN)
                    fixed_bits = {fixed_bits[55:0], b};
                else
                    skip_cnt = {skip_cnt[7:0], b};
                if (fld_pos >= FIXED_LAST_POS) begin
                    if (fixed_bits[63:48] == TYPE_A) begin
                        parse_state = PARSE_ADDR;
                        fld_pos     = '0;
                        addr_acc    = '0;
                    end else if (skip_cnt != 0) begin
                        parse_state = PARSE_RSKIP;
                    end else begin
                        next_answer();
                    end
                end else begin
                    fld_pos = fld_pos + 4'd1;
                end
            end
            PARSE_ADDR:
            begin
                if (fld_pos >= ADDR_LAST_POS) begin
                    item.kind         = KIND_ADDRESS;
                    item.ipv4_address = {addr_acc, b};
                    item.time_to_live = fixed_bits[31:0];
                    item.record_class = fixed_bits[47:32];
                    emit              = 1'b1;
                    found             = 1'b1;
                    parse_state       = PARSE_DONE;
                end else begin
                    addr_acc = {addr_acc[15:0], b};
                    fld_pos  = fld_pos + 4'd1;
                end
            end
            PARSE_RSKIP:
            begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0)
                    next_answer();
            end
            default:
            begin
            end
        endcase
        // A status on the last byte replaces any character from that byte.
        if (last) begin
            if (parse_state == PARSE_BAD) begin
                item      = '0;
                item.kind = KIND_MALFORMED;
                emit      = 1'b1;
            end else if (!found) begin
                item      = '0;
                item.kind = KIND_NO_ADDRESS;
                emit      = 1'b1;
            end
            reset_parser();
        end
        if (emit)
            expected_items.push_back(item);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $error("%s: expected %0h, got %0h", field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        extract_item_t got;
        extract_item_t want;
        if (!rst_n) begin
            reset_parser();
            expected_items.delete();
            outstanding <= 0;
        end else begin
            if (msg.valid && msg.ready)
                parse_byte(msg.data_byte, msg.last_byte);
            if (result.valid && result.ready) begin
                got.kind           = result.kind;
                got.name_char      = result.name_char;
                got.question_index = result.question_index;
                got.ipv4_address   = result.ipv4_address;
                got.time_to_live   = result.time_to_live;
                got.record_class   = result.record_class;
                if (expected_items.size() == 0) begin
                    failures++;
                    $error("unexpected result: kind %0d", got.kind);
                end else begin
                    want = expected_items.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("name_char", want.name_char, got.name_char);
                    check_field("question_index", want.question_index, got.question_index);
                    check_field("ipv4_address", want.ipv4_address, got.ipv4_address);
                    check_field("time_to_live", want.time_to_live, got.time_to_live);
                    check_field("record_class", want.record_class, got.record_class);
                end
            end
            outstanding <= expected_items.size();
        end
    end

endmodule

FILE: sim/tb_dns_answer_address_extract.sv
module tb_dns_answer_address_extract;
    import dnsae_pkg::*;

    // Receiver hold-off long enough to back the block up into its input side.
    localparam int HOLD_CYCLES   = 300;
    // Cycles without any request on either channel before the run is abandoned.
    localparam int STALL_LIMIT   = 3000;
    // Settling wait after the last drain, covering the input register and parser.
    localparam int SETTLE_CYCLES = 6;
    localparam int TARGET_BYTES  = 700;

    logic clk;
    logic rst_n;

    dnsae_msg_if    msg_ch ();
    dnsae_result_if result_ch ();

    int failures;
    int outstanding;
    int stalled_cycles;
    int results_taken;

    // Bytes of the message being built; sent front to back.
    logic [7:0] frame[$];
    // Set per message: no idling on the sending side for its whole length.
    bit steady;

    dns_answer_address_extract DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .result (result_ch)
    );

    address_extract_checker answer_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg         (msg_ch),
        .result      (result_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length for either side: mostly none or a few cycles, now and then a long gap.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 60);
    endfunction

    // Label lengths: mostly short names, with the 63-byte maximum turning up regularly.
    function automatic int label_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        else if (r < 88)
            return $urandom_range(7, 62);
        else
            return 63;
    endfunction

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            frame.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_labels(input int count);
        int len;
        for (int i = 0; i < count; i++) begin
            len = label_length();
            frame.push_back(8'(len));
            add_random(len);
        end
    endtask

    task automatic add_word(input logic [15:0] w);
        frame.push_back(w[15:8]);
        frame.push_back(w[7:0]);
    endtask

    // Build a response: random header flags, a few questions and answers with random
    // content. With bad_label set, one question name carries a length byte of 64..255
    // and the rest of the message is noise.
    task automatic build_response(input bit bad_label);
        int          qd;
        int          an;
        int          bad_q;
        int          rdlen;
        int          r;
        logic [15:0] rtype;
        frame.delete();
        qd = $urandom_range(0, 2);
        an = $urandom_range(0, 3);
        if (bad_label && qd == 0)
            qd = 1;
        bad_q = bad_label ? $urandom_range(0, qd - 1) : -1;
        add_random(4);
        add_word(16'(qd));
        add_word(16'(an));
        add_random(4);
        for (int q = 0; q < qd; q++) begin
            if (q == bad_q) begin
                add_labels($urandom_range(0, 1));
                r = $urandom_range(0, 3);
                frame.push_back(r == 0 ? 8'd64 : r == 1 ? 8'd255
                                : 8'($urandom_range(65, 254)));
                add_random($urandom_range(0, 20));
                return;
            end
            add_labels($urandom_range(0, 3));
            frame.push_back(8'h00);
            add_random(4);
        end
        for (int a = 0; a < an; a++) begin
            // Answer name: bare pointer, labels, labels then pointer, or an odd length byte.
            case ($urandom_range(0, 3))
                0:
                begin
                    frame.push_back(POINTER_MASK | 8'($urandom_range(0, 63)));
                    add_random(1);
                end
                1:
                begin
                    add_labels($urandom_range(1, 3));
                    frame.push_back(8'h00);
                end
                2:
                begin
                    add_labels($urandom_range(1, 2));
                    frame.push_back(POINTER_MASK | 8'($urandom_range(0, 63)));
                    add_random(1);
                end
                default:
                begin
                    frame.push_back(8'($urandom_range(64, 191)));
                end
            endcase
            r = $urandom_range(0, 9);
            if (r < 5)
                rtype = TYPE_A;
            else if (r == 5)
                rtype = 16'h0100;
            else if (r == 6)
                rtype = 16'd28;
            else if (r == 7)
                rtype = 16'd5;
            else
                rtype = 16'($urandom_range(0, 65535));
            add_word(rtype);
            add_word($urandom_range(0, 1) ? 16'd1 : 16'($urandom_range(0, 65535)));
            add_random(4);
            if (rtype == TYPE_A)
                rdlen = ($urandom_range(0, 9) != 0) ? 4 : $urandom_range(0, 8);
            else
                rdlen = $urandom_range(0, 6);
            add_word(16'(rdlen));
            add_random(rtype == TYPE_A ? 4 : rdlen);
        end
        add_random($urandom_range(0, 3));
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = steady ? 0 : idle_cycles();
        if (gap > 0) begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.data_byte <= b;
        msg_ch.last_byte <= last;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
    endtask

    // Send the first count bytes of the frame, marking the final one as last.
    task automatic send_frame(input int count);
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
            send_byte(frame[i], i == count - 1);
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic drain();
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiving side: runs of ready broken by random gaps, and a single long hold-off
    // once traffic is flowing, while the sender keeps offering.
    initial
    begin : result_side
        int run;
        int gap;
        bit held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (!held && results_taken >= 60 && msg_ch.valid) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            result_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = idle_cycles();
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Count taken results and watch for a run with no progress on either channel.
    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (result_ch.valid && result_ch.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (result_ch.valid && result_ch.ready)
            results_taken <= results_taken + 1;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("tb_dns_answer_address_extract: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        int bytes_sent;
        int messages;
        int len;
        int r;
        bytes_sent       = 0;
        messages         = 0;
        steady           = 1'b0;
        rst_n            <= 1'b0;
        msg_ch.valid     <= 1'b0;
        msg_ch.data_byte <= 8'h00;
        msg_ch.last_byte <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a one-byte message ending inside the header.
        frame.delete();
        frame.push_back(8'hff);
        send_frame(1);

        // Directed: header of all-ones flags, one question whose first length byte
        // is 64, which is also the last byte, so the malformed status is reported.
        frame.delete();
        for (int i = 0; i < 12; i++)
            frame.push_back(i == 5 ? 8'h01 : (i == 4 || i == 6 || i == 7) ? 8'h00 : 8'hff);
        frame.push_back(8'd64);
        send_frame(frame.size());

        // Directed: short message of mixed extremes, no address found.
        frame.delete();
        frame.push_back(8'h00);
        frame.push_back(8'h80);
        frame.push_back(8'h7f);
        frame.push_back(8'h01);
        send_frame(4);
        drain();

        // Random: mostly complete responses, some with bad question labels,
        // some cut short, some plain noise.
        while (bytes_sent < TARGET_BYTES) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                build_response(1'b0);
                len = frame.size();
            end else if (r == 6) begin
                build_response(1'b1);
                len = frame.size();
            end else if (r < 9) begin
                build_response(1'b0);
                len = $urandom_range(1, frame.size());
            end else begin
                frame.delete();
                add_random($urandom_range(1, 24));
                len = frame.size();
            end
            send_frame(len);
            bytes_sent += len;
            messages++;
            if (messages == 6)
                drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("tb_dns_answer_address_extract: done, clean");
        else
            $display("tb_dns_answer_address_extract: done, errors");
        $finish;
    end

endmodule

FILE: dns_answer_address_extract.f
+incdir+hw/rtl
hw/rtl/dnsae_pkg.sv
hw/rtl/dnsae_msg_if.sv
hw/rtl/dnsae_result_if.sv
hw/rtl/dns_answer_address_extract.sv
sim/address_extract_checker.sv
sim/tb_dns_answer_address_extract.sv
